@@ hw/rtl/ets_pkg.sv @@
`timescale 1ns / 1ps

package ets_pkg;

	// event word fields
	localparam int BOARD_W  = 3;
	localparam int CHAN_W   = 4;
	localparam int TAG_W    = 31;
	localparam int EXTRAS_W = 32;
	localparam int ENERGY_W = 16;
	localparam int TIME_W   = 64;
	localparam int HALF_W   = 16;
	localparam int FINE_W   = 10;

	// per-slot state
	localparam int WRAP_W = 33;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int MODE_W     = 2;
	localparam int CFD_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FINE_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CFD_INTERP    = 2'd2;

	localparam logic [MODE_W-1:0] MODE_ZC = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HW = 2'd2;

	// sample period kept in picoseconds
	localparam int PERIOD_PS_W = 18;
	localparam int PS_PER_NS   = 1000;
	localparam logic [PERIOD_PS_W-1:0] PERIOD_PS_RST = 18'd2000;

	// hardware fine value full scale, one less than 2^FINE_W
	localparam int HW_FINE_SCALE = 1023;
	// period in ps times the fine value, plus half the scale
	localparam int HW_NUM_W = 28;
	localparam int HW_T1_W  = HW_NUM_W - FINE_W + 1;
	localparam int HW_T2_W  = FINE_W + 1;

	// shared multiplier
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 18;
	localparam int MUL_W   = MUL_A_W + MUL_B_W;

	// shared divider
	localparam int QUO_W  = 21;
	localparam int DVSR_W = 17;
	localparam int DVND_W = 38;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

@@ hw/rtl/ets_intf.sv @@
`timescale 1ns / 1ps

interface ets_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ets_pkg::CFG_IDX_W-1:0]   index;
	logic [ets_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

interface ets_in_if;
	logic                           valid;
	logic                           ready;
	logic [ets_pkg::BOARD_W-1:0]    board;
	logic [ets_pkg::CHAN_W-1:0]     channel;
	logic [ets_pkg::TAG_W-1:0]      time_tag;
	logic [ets_pkg::EXTRAS_W-1:0]   extras;
	logic [ets_pkg::ENERGY_W-1:0]   energy;

	modport source(output valid, board, channel, time_tag, extras, energy, input ready);
	modport sink(input valid, board, channel, time_tag, extras, energy, output ready);
endinterface

interface ets_out_if;
	logic                           valid;
	logic                           ready;
	logic [ets_pkg::BOARD_W-1:0]    out_board;
	logic [ets_pkg::CHAN_W-1:0]     out_channel;
	logic [ets_pkg::ENERGY_W-1:0]   out_energy;
	logic [ets_pkg::TIME_W-1:0]     time_ps;

	modport source(output valid, out_board, out_channel, out_energy, time_ps, input ready);
	modport sink(input valid, out_board, out_channel, out_energy, time_ps, output ready);
endinterface

@@ hw/rtl/ets_div.sv @@
`timescale 1ns / 1ps

module ets_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ets_pkg::DVND_W-1:0]    dividend,
	input  logic [ets_pkg::DVSR_W-1:0]    divisor,
	output logic [ets_pkg::QUO_W-1:0]     quotient,
	output ets_pkg::div_sts_t             sts
);
	import ets_pkg::*;

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVSR_W-1:0] rem_q;
	logic [DVSR_W-1:0] dvsr_q;
	logic [QUO_W-1:0]  quo_q;

	logic [DVSR_W:0]   trial;
	logic [DVSR_W:0]   diff;
	logic              fits;

	// one restoring step: bring down the next dividend bit
	always_comb begin
		trial = {rem_q, quo_q[QUO_W-1]};
		diff  = trial - {1'b0, dvsr_q};
		fits  = (trial >= {1'b0, dvsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(QUO_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// the quotient is known to fit QUO_W bits, so the top bits seed the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend[DVND_W-1:QUO_W];
			quo_q  <= dividend[QUO_W-1:0];
			dvsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

@@ hw/rtl/event_timestamp_builder.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake    Word
// cfg      in   valid/ready  index, data (fine_mode, sample_period_ns, cfd_interp)
// evt      in   valid/ready  board, channel, time_tag, extras, energy
// ts       out  valid/ready  out_board, out_channel, out_energy, time_ps
//
// One event at a time: after S_RD and S_M0 to S_M2 an event goes to S_FIN in
// coarse mode or with a zero-crossing that is not bracketed, via S_HW0 and S_HW1
// with the hardware fine time, or via S_M3, S_DINIT and S_DIV when a crossing is
// divided out; the shared 32x18 multiplier and the 21-step shared divider do the
// arithmetic; evt is ready again in the cycle ts shows the result. After reset
// the slot memory is cleared, one slot per cycle, with evt held not ready; cfg
// is always ready. A result waits in the ts register while the next event is taken.
module event_timestamp_builder #(
	parameter int NUM_BOARDS   = 8,
	parameter int NUM_CHANNELS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ets_cfg_if.sink    cfg,
	ets_in_if.sink     evt,
	ets_out_if.source  ts
);
	import ets_pkg::*;

	localparam int SLOTS   = NUM_BOARDS * NUM_CHANNELS;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ENTRY_W = WRAP_W + TAG_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_RD,
		S_M0,
		S_M1,
		S_M2,
		S_M3,
		S_HW0,
		S_HW1,
		S_DINIT,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [MODE_W-1:0]      fine_mode_q;
	logic [PERIOD_PS_W-1:0] period_ps_q;
	logic [CFD_W-1:0]       cfd_q;

	// event held for the duration of the work
	logic [BOARD_W-1:0]  board_q;
	logic [CHAN_W-1:0]   channel_q;
	logic [TAG_W-1:0]    tag_q;
	logic [EXTRAS_W-1:0] extras_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                use_mem_q;
	logic [SLOT_W-1:0]   clr_q;

	logic [TIME_W-1:0]   coarse_q;
	logic [TIME_W-1:0]   acc_q;
	logic [MUL_W-1:0]    mul_q;

	logic                ts_valid_q;
	logic [BOARD_W-1:0]  ts_board_q;
	logic [CHAN_W-1:0]   ts_channel_q;
	logic [ENERGY_W-1:0] ts_energy_q;
	logic [TIME_W-1:0]   ts_time_q;

	// slot memory
	logic [ENTRY_W-1:0]  slot_mem [SLOTS];
	logic [ENTRY_W-1:0]  mem_rd_q;
	logic                mem_re;
	logic                mem_we;
	logic [SLOT_W-1:0]   mem_wa;
	logic [ENTRY_W-1:0]  mem_wd;

	logic                evt_acc;
	logic                evt_in_range;
	logic [SLOT_W-1:0]   evt_slot;
	logic                fin_load;

	logic [TAG_W-1:0]    prev_tag;
	logic [WRAP_W-1:0]   prev_wrap;
	logic [WRAP_W-1:0]   wrap_new;

	logic                zc_hit;
	logic [HALF_W-1:0]   neg_mag;
	logic [HALF_W-1:0]   zc_den;

	logic [HW_NUM_W-1:0]  hw_y;
	logic [HW_T1_W-2:0]   hw_a_q;
	logic [HW_T1_W-1:0]   hw_t1_q;
	logic [HW_T2_W-1:0]   hw_t2;
	logic [HW_T1_W-1:0]   hw_q;

	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;

	logic                div_start;
	logic [DVND_W-1:0]   div_dvnd;
	logic [DVSR_W-1:0]   div_dvsr;
	logic [QUO_W-1:0]    div_quo;
	div_sts_t            div_sts;

	assign cfg.ready = 1'b1;
	assign evt.ready = (state_q == S_IDLE);
	assign evt_acc   = evt.valid && evt.ready;

	assign evt_in_range = (int'(evt.board) < NUM_BOARDS) && (int'(evt.channel) < NUM_CHANNELS);
	assign evt_slot     = SLOT_W'(int'(evt.board) * NUM_CHANNELS + int'(evt.channel));
	assign mem_re       = evt_acc && evt_in_range && (fine_mode_q != MODE_HW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_mode_q <= '0;
			period_ps_q <= PERIOD_PS_RST;
			cfd_q       <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FINE_MODE:     fine_mode_q <= cfg.data[MODE_W-1:0];
				REG_SAMPLE_PERIOD: period_ps_q <= PERIOD_PS_W'(cfg.data) * PERIOD_PS_W'(PS_PER_NS);
				REG_CFD_INTERP:    cfd_q       <= cfg.data[CFD_W-1:0];
				default:           ;
			endcase
		end
	end

	// unwrap: advance the wrap count when the tag goes backwards
	assign prev_tag  = mem_rd_q[TAG_W-1:0];
	assign prev_wrap = mem_rd_q[ENTRY_W-1:TAG_W];
	assign wrap_new  = (tag_q < prev_tag) ? prev_wrap + WRAP_W'(1) : prev_wrap;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot_q;
		mem_wd = {wrap_new, tag_q};
		if (state_q == S_CLR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (state_q == S_RD) begin
			mem_we = use_mem_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= slot_mem[evt_slot];
		end
	end

	// zero crossing: negative sample in the low half, non-negative in the high half
	assign zc_hit  = extras_q[HALF_W-1] && !extras_q[EXTRAS_W-1];
	assign neg_mag = HALF_W'(0) - extras_q[HALF_W-1:0];
	assign zc_den  = extras_q[EXTRAS_W-1:HALF_W] + neg_mag;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_M0: begin
				mul_a = coarse_q[MUL_A_W-1:0];
				mul_b = period_ps_q;
			end
			S_M1: begin
				mul_a = coarse_q[TIME_W-1:MUL_A_W];
				mul_b = period_ps_q;
			end
			S_M2: begin
				mul_a = MUL_A_W'(period_ps_q);
				mul_b = (fine_mode_q == MODE_HW) ? MUL_B_W'(extras_q[FINE_W-1:0])
				                                 : MUL_B_W'({cfd_q, 1'b1});
			end
			S_M3: begin
				mul_a = MUL_A_W'(mul_q[QUO_W-1:0]);
				mul_b = MUL_B_W'(neg_mag);
			end
			default: ;
		endcase
	end

	// hardware fine time: (num + 511) / 1023; fold the bits above FINE_W back
	// onto the low ones twice, then correct by one
	assign hw_y  = mul_q[HW_NUM_W-1:0] + HW_NUM_W'(HW_FINE_SCALE / 2);
	assign hw_t2 = HW_T2_W'(hw_t1_q[HW_T1_W-1:FINE_W]) + HW_T2_W'(hw_t1_q[FINE_W-1:0]);
	assign hw_q  = HW_T1_W'(hw_a_q) + HW_T1_W'(hw_t1_q[HW_T1_W-1:FINE_W])
	             + HW_T1_W'(hw_t2 >= HW_T2_W'(HW_FINE_SCALE));

	// rounded quotient: (2*num + den) / (2*den)
	assign div_start = (state_q == S_DINIT);
	assign div_dvsr  = {zc_den, 1'b0};
	assign div_dvnd  = {mul_q[DVND_W-2:0], 1'b0} + DVND_W'(zc_den);

	ets_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvnd),
		.divisor  (div_dvsr),
		.quotient (div_quo),
		.sts      (div_sts)
	);

	assign fin_load = (state_q == S_FIN) && (!ts_valid_q || ts.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			ts_valid_q <= 1'b0;
		end else begin
			if (fin_load) begin
				ts_valid_q <= 1'b1;
			end else if (ts.ready) begin
				ts_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (evt_acc) begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_M0;
				S_M0: state_q <= S_M1;
				S_M1: state_q <= S_M2;
				S_M2: begin
					if (fine_mode_q == MODE_HW) begin
						state_q <= S_HW0;
					end else if (fine_mode_q == MODE_ZC && zc_hit) begin
						state_q <= S_M3;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_M3:    state_q <= S_DINIT;
				S_HW0:   state_q <= S_HW1;
				S_HW1:   state_q <= S_FIN;
				S_DINIT: state_q <= S_DIV;
				S_DIV: begin
					if (div_sts.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
		if (evt_acc) begin
			board_q   <= evt.board;
			channel_q <= evt.channel;
			tag_q     <= evt.time_tag;
			extras_q  <= evt.extras;
			energy_q  <= evt.energy;
			slot_q    <= evt_slot;
			use_mem_q <= evt_in_range && (fine_mode_q != MODE_HW);
		end
		if (state_q == S_RD) begin
			if (fine_mode_q == MODE_HW) begin
				coarse_q <= TIME_W'({extras_q[EXTRAS_W-1:HALF_W], tag_q});
			end else if (use_mem_q) begin
				coarse_q <= {wrap_new, tag_q};
			end else begin
				coarse_q <= TIME_W'(tag_q);
			end
		end
		if (state_q == S_HW0) begin
			hw_a_q  <= hw_y[HW_NUM_W-1:FINE_W];
			hw_t1_q <= HW_T1_W'(hw_y[HW_NUM_W-1:FINE_W]) + HW_T1_W'(hw_y[FINE_W-1:0]);
		end
		// coarse * period: low half product, then high half shifted by 32
		if (state_q == S_M1) begin
			acc_q <= TIME_W'(mul_q);
		end else if (state_q == S_M2) begin
			acc_q <= acc_q + {mul_q[MUL_A_W-1:0], MUL_A_W'(0)};
		end else if (state_q == S_HW1) begin
			acc_q <= acc_q + TIME_W'(hw_q);
		end else if (state_q == S_DIV && div_sts.done) begin
			acc_q <= acc_q + TIME_W'(div_quo);
		end
		if (fin_load) begin
			ts_board_q   <= board_q;
			ts_channel_q <= channel_q;
			ts_energy_q  <= energy_q;
			ts_time_q    <= acc_q;
		end
	end

	assign ts.valid       = ts_valid_q;
	assign ts.out_board   = ts_board_q;
	assign ts.out_channel = ts_channel_q;
	assign ts.out_energy  = ts_energy_q;
	assign ts.time_ps     = ts_time_q;

`ifndef ASSERT_OFF
	a_clr_blocks_evt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !evt.ready)
		else $error("event accepted during slot clear");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.ready |=> !evt.ready)
		else $error("second event taken while one is in work");

	a_hw_no_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q != S_CLR |-> fine_mode_q != MODE_HW)
		else $error("slot state written in hardware fine mode");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ts.valid) |-> $past(state_q == S_FIN))
		else $error("result shown without finishing an event");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == S_DIV)
		else $error("divider finished while sequencer not waiting");
`endif

endmodule

@@ sim/event_timestamp_builder_tb.sv @@
`timescale 1ns / 1ps

module event_timestamp_builder_tb;
	import ets_pkg::*;

	localparam int NUM_BOARDS     = 8;
	localparam int NUM_CHANNELS   = 16;
	localparam int NUM_SLOTS      = NUM_BOARDS * NUM_CHANNELS;
	localparam int TIMEOUT_CYCLES = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RAND_PHASES    = 8;
	localparam int PHASE_ITEMS    = 60;

	localparam logic [MODE_W-1:0] MODE_COARSE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

	typedef struct packed {
		logic [BOARD_W-1:0]  board;
		logic [CHAN_W-1:0]   channel;
		logic [TAG_W-1:0]    time_tag;
		logic [EXTRAS_W-1:0] extras;
		logic [ENERGY_W-1:0] energy;
	} event_word_t;

	typedef struct packed {
		logic [BOARD_W-1:0]  board;
		logic [CHAN_W-1:0]   channel;
		logic [ENERGY_W-1:0] energy;
		logic [TIME_W-1:0]   time_ps;
	} stamp_t;

	class stamp_tracker;
		stamp_t                 stamps_due[$];
		int                     mismatches;
		logic [MODE_W-1:0]      mode;
		logic [CFG_DATA_W-1:0]  period_ns;
		logic [CFD_W-1:0]       cfd;
		logic [TAG_W-1:0]       last_tag [NUM_SLOTS];
		logic [WRAP_W-1:0]      wraps [NUM_SLOTS];

		function new();
			mismatches = 0;
			mode = MODE_COARSE;
			period_ns = 8'd2;
			cfd = '0;
			foreach (last_tag[i]) begin
				last_tag[i] = '0;
				wraps[i] = '0;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FINE_MODE: begin
					mode = data[MODE_W-1:0];
				end
				REG_SAMPLE_PERIOD: begin
					period_ns = data;
				end
				REG_CFD_INTERP: begin
					cfd = data[CFD_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function int pending();
			return stamps_due.size();
		endfunction

		// work out the timestamp of one accepted event and queue it
		function void note_event(event_word_t e);
			logic [63:0]        coarse, fine, ext, cnt, num, den, dt, mag;
			logic signed [15:0] pos, neg;
			int                 slot;
			stamp_t             s;
			fine = '0;
			if (mode == MODE_HW) begin
				ext = 64'(e.extras[31:16]) << 31;
				coarse = (64'(e.time_tag) + ext) * 64'(period_ns);
				num = 64'(period_ns) * 64'd1000 * 64'(e.extras[FINE_W-1:0]);
				fine = (2 * num + 64'd1023) / 64'd2046;
			end else begin
				cnt = '0;
				if (e.board < NUM_BOARDS && e.channel < NUM_CHANNELS) begin
					slot = int'(e.board) * NUM_CHANNELS + int'(e.channel);
					if (e.time_tag < last_tag[slot])
						wraps[slot] = wraps[slot] + 1'b1;
					last_tag[slot] = e.time_tag;
					cnt = 64'(wraps[slot]);
				end
				coarse = (64'(e.time_tag) + (cnt << 31)) * 64'(period_ns);
				if (mode == MODE_ZC) begin
					pos = e.extras[31:16];
					neg = e.extras[15:0];
					// only a bracketed crossing gives a fine time
					if (neg < 0 && pos >= 0) begin
						dt = 64'(1 + 2 * int'(cfd)) * 64'(period_ns);
						mag = 64'(-int'(neg));
						den = 64'(int'(pos) - int'(neg));
						num = dt * 64'd1000 * mag;
						fine = (2 * num + den) / (2 * den);
					end
				end
			end
			s.board = e.board;
			s.channel = e.channel;
			s.energy = e.energy;
			s.time_ps = coarse * 64'd1000 + fine;
			stamps_due = {stamps_due, s};
		endfunction

		function void compare_field(string what, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
				mismatches++;
			end
		endfunction

		function void check_stamp(stamp_t got);
			stamp_t want;
			if (stamps_due.size() == 0) begin
				$display("%0t: timestamp word with none due, expected nothing, actual %h",
					$time, got);
				mismatches++;
				return;
			end
			want = stamps_due[0];
			stamps_due.delete(0);
			compare_field("out_board", 64'(want.board), 64'(got.board));
			compare_field("out_channel", 64'(want.channel), 64'(got.channel));
			compare_field("out_energy", 64'(want.energy), 64'(got.energy));
			compare_field("time_ps", want.time_ps, got.time_ps);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ets_cfg_if cfg_if();
	ets_in_if  evt_if();
	ets_out_if ts_if();

	stamp_tracker tracker = new();
	int           sent = 0;
	int           quiet_cycles = 0;

	event_timestamp_builder #(
		.NUM_BOARDS(NUM_BOARDS),
		.NUM_CHANNELS(NUM_CHANNELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.evt(evt_if),
		.ts(ts_if)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic send_event(input logic [BOARD_W-1:0] b, input logic [CHAN_W-1:0] c,
			input logic [TAG_W-1:0] tag, input logic [EXTRAS_W-1:0] xtra,
			input logic [ENERGY_W-1:0] nrg);
		event_word_t w;
		w = '{board: b, channel: c, time_tag: tag, extras: xtra, energy: nrg};
		// no gaps in the middle stretch
		while (!(sent >= 220 && sent < 320) && $urandom_range(0, 99) < 28) begin
			evt_if.valid <= 1'b0;
			@(posedge clk);
		end
		evt_if.valid <= 1'b1;
		evt_if.board <= w.board;
		evt_if.channel <= w.channel;
		evt_if.time_tag <= w.time_tag;
		evt_if.extras <= w.extras;
		evt_if.energy <= w.energy;
		do @(posedge clk); while (!evt_if.ready);
		tracker.note_event(w);
		sent++;
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		tracker.set_reg(idx, data);
	endtask

	// drain, then load all three registers back to back
	task automatic write_setup(input logic [MODE_W-1:0] mode, input logic [CFG_DATA_W-1:0] period,
			input logic [CFD_W-1:0] cfd);
		evt_if.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		put_reg(REG_FINE_MODE, CFG_DATA_W'(mode));
		put_reg(REG_SAMPLE_PERIOD, period);
		put_reg(REG_CFD_INTERP, CFG_DATA_W'(cfd));
		cfg_if.valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [MODE_W-1:0]     mode;
		logic [CFG_DATA_W-1:0] period;
		logic [CFD_W-1:0]      cfd;
		logic [BOARD_W-1:0]    b;
		logic [CHAN_W-1:0]     c;
		logic [TAG_W-1:0]      tag;
		logic [EXTRAS_W-1:0]   xtra;
		int                    pick;

		arst_n <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= '0;
		cfg_if.data <= '0;
		evt_if.valid <= 1'b0;
		evt_if.board <= '0;
		evt_if.channel <= '0;
		evt_if.time_tag <= '0;
		evt_if.extras <= '0;
		evt_if.energy <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: coarse only, tag extremes and a wrap
		send_event(3'd0, 4'd0, 31'h7FFFFFFF, 32'h0000_0000, 16'hFFFF);
		send_event(3'd0, 4'd0, 31'h0000_0000, 32'hFFFF_FFFF, 16'h0000);
		send_event(3'd7, 4'd15, 31'h2AAA_AAAA, 32'h5555_5555, 16'h5555);
		send_event(3'd7, 4'd15, 31'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA);

		// zero crossing, widest window
		write_setup(MODE_ZC, 8'd255, 2'd3);
		send_event(3'd1, 4'd2, 31'd5, {16'h7FFF, 16'h8000}, 16'd1);
		send_event(3'd1, 4'd2, 31'd6, {16'h0000, 16'hFFFF}, 16'd2);
		send_event(3'd1, 4'd2, 31'd7, {16'h7FFF, 16'hFFFF}, 16'd3);
		send_event(3'd1, 4'd2, 31'd8, {16'h0000, 16'h8000}, 16'd4);
		// crossing not bracketed
		send_event(3'd1, 4'd2, 31'd9, {16'd100, 16'h0000}, 16'd5);
		send_event(3'd1, 4'd2, 31'd3, {16'hFFFF, 16'hFFFB}, 16'd6);

		// hardware fine time and tag extension
		write_setup(MODE_HW, 8'd255, 2'd0);
		send_event(3'd2, 4'd9, 31'h7FFFFFFF, 32'hFFFF_03FF, 16'd7);
		send_event(3'd2, 4'd9, 31'd0, 32'h0000_0000, 16'd8);
		send_event(3'd2, 4'd9, 31'd1000, 32'h0000_0200, 16'd9);
		send_event(3'd2, 4'd9, 31'd1, 32'hFFFF_FFFF, 16'd10);

		// unused mode value falls back to coarse with unwrap
		write_setup(MODE_SPARE, 8'd1, 2'd1);
		send_event(3'd0, 4'd0, 31'd3, 32'h1234_8765, 16'd11);
		send_event(3'd0, 4'd0, 31'd1, 32'h1234_8765, 16'd12);

		// zero sample period
		write_setup(MODE_ZC, 8'd0, 2'd2);
		send_event(3'd5, 4'd3, 31'h4000_0000, {16'd200, 16'hFF00}, 16'd13);
		send_event(3'd5, 4'd3, 31'd17, {16'd200, 16'hFF00}, 16'd14);

		for (int p = 0; p < RAND_PHASES; p++) begin
			mode = MODE_W'(p % 4);
			case (p)
				0, 6: period = 8'd1;
				1, 4: period = 8'd255;
				3: period = 8'd2;
				default: period = 8'($urandom_range(1, 255));
			endcase
			cfd = (p == 1) ? 2'd3 : (p == 5) ? 2'd0 : CFD_W'($urandom_range(0, 3));
			write_setup(mode, period, cfd);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// crowd a few slots so wrap counts build up
				if ($urandom_range(0, 1)) begin
					b = BOARD_W'($urandom);
					c = CHAN_W'($urandom);
				end else begin
					b = $urandom_range(0, 1) ? 3'd7 : 3'd0;
					c = (b != 0) ? 4'd15 : 4'd0;
				end
				pick = $urandom_range(0, 9);
				case (pick)
					0, 1, 2, 3: tag = TAG_W'($urandom);
					4, 5: tag = 31'h7FFFFFFF - TAG_W'($urandom_range(0, 1000));
					6, 7: tag = TAG_W'($urandom_range(0, 1000));
					8: tag = 31'h7FFFFFFF;
					default: tag = '0;
				endcase
				if ($urandom_range(0, 9) < 6)
					xtra = {16'($urandom_range(0, 32767)),
						16'(32'h10000 - $urandom_range(1, 32768))};
				else
					xtra = $urandom;
				send_event(b, c, tag, xtra, ENERGY_W'($urandom));
			end
		end

		evt_if.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// result side: random stalls, a stretch with no stalls, and two long hold-offs
	initial begin : sink
		int got;
		got = 0;
		ts_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (ts_if.valid && ts_if.ready) begin
				got++;
				if (got == 150 || got == 400) begin
					ts_if.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
			end
			ts_if.ready <= (got >= 200 && got < 300) || ($urandom_range(0, 99) >= 28);
		end
	end

	always @(posedge clk) begin
		if (ts_if.valid && ts_if.ready)
			tracker.check_stamp('{board: ts_if.out_board, channel: ts_if.out_channel,
				energy: ts_if.out_energy, time_ps: ts_if.time_ps});
	end

	// end the run if nothing moves on any channel for too long
	always @(posedge clk) begin
		if ((ts_if.valid && ts_if.ready) || (evt_if.valid && evt_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= TIMEOUT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
